/* hw/rtl/qs_pkg.sv */
// Package for the quicksort engine: beat payload types, controller states,
// and the command and status records between controller and datapath.
// No dependencies.
package qs_pkg;

    localparam int ValueW = 32;

    typedef struct packed {
        logic signed [ValueW-1:0] value;
        logic                     last;
    } t_in_beat;

    typedef struct packed {
        logic signed [ValueW-1:0] sorted_value;
        logic                     last_res;
        logic                     overflow;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_RANGE,
        ST_PIV_RD,
        ST_PIV_LD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_I,
        ST_SWAP_J,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_EM_RD,
        ST_EM_OUT
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic push_init;
        logic pop;
        logic range_ld;
        logic pivot_rd;
        logic pivot_ld;
        logic scan_rd;
        logic i_inc;
        logic j_dec;
        logic swap_i;
        logic swap_j;
        logic push_l;
        logic push_r;
        logic emit_rd;
        logic emit_next;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic cnt_lt2;
        logic sp_zero;
        logic range_ok;
        logic i_go;
        logic j_go;
        logic i_le_j;
        logic swap_cont;
        logic j_gt_lo;
        logic i_lt_hi;
        logic emit_last;
    } t_status;

endpackage

/* hw/rtl/qs_stream_if.sv */
// Valid/ready stream channel carrying one payload per beat.
// Payload type is a parameter; used with the qs_pkg beat types.
interface qs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/qs_ctrl.sv */
// Controller state machine of the quicksort engine.
// Depends on qs_pkg; drives t_cmd to qs_datapath and reads its t_status.
module qs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  qs_pkg::t_status i_status,
    output qs_pkg::t_cmd    o_cmd
);

    qs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qs_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qs_pkg::ST_LOAD: begin
                if (i_in_valid && i_in_last) n_state = qs_pkg::ST_INIT;
            end
            qs_pkg::ST_INIT: begin
                n_state = i_status.cnt_lt2 ? qs_pkg::ST_EM_RD : qs_pkg::ST_POP;
            end
            qs_pkg::ST_POP: begin
                n_state = i_status.sp_zero ? qs_pkg::ST_EM_RD : qs_pkg::ST_RANGE;
            end
            qs_pkg::ST_RANGE: begin
                n_state = i_status.range_ok ? qs_pkg::ST_PIV_RD : qs_pkg::ST_POP;
            end
            qs_pkg::ST_PIV_RD:  n_state = qs_pkg::ST_PIV_LD;
            qs_pkg::ST_PIV_LD:  n_state = qs_pkg::ST_SCAN_RD;
            qs_pkg::ST_SCAN_RD: n_state = qs_pkg::ST_SCAN_CMP;
            qs_pkg::ST_SCAN_CMP: begin
                if (i_status.i_go || i_status.j_go) n_state = qs_pkg::ST_SCAN_RD;
                else if (i_status.i_le_j)           n_state = qs_pkg::ST_SWAP_I;
                else                                n_state = qs_pkg::ST_PUSH_L;
            end
            qs_pkg::ST_SWAP_I:  n_state = qs_pkg::ST_SWAP_J;
            qs_pkg::ST_SWAP_J: begin
                n_state = i_status.swap_cont ? qs_pkg::ST_SCAN_RD : qs_pkg::ST_PUSH_L;
            end
            qs_pkg::ST_PUSH_L:  n_state = qs_pkg::ST_PUSH_R;
            qs_pkg::ST_PUSH_R:  n_state = qs_pkg::ST_POP;
            qs_pkg::ST_EM_RD:   n_state = qs_pkg::ST_EM_OUT;
            qs_pkg::ST_EM_OUT: begin
                if (i_out_ready) begin
                    n_state = i_status.emit_last ? qs_pkg::ST_LOAD : qs_pkg::ST_EM_RD;
                end
            end
            default: n_state = qs_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            qs_pkg::ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load_wr = i_in_valid;
            end
            qs_pkg::ST_INIT:    o_cmd.push_init = !i_status.cnt_lt2;
            qs_pkg::ST_POP:     o_cmd.pop = !i_status.sp_zero;
            qs_pkg::ST_RANGE:   o_cmd.range_ld = 1'b1;
            qs_pkg::ST_PIV_RD:  o_cmd.pivot_rd = 1'b1;
            qs_pkg::ST_PIV_LD:  o_cmd.pivot_ld = 1'b1;
            qs_pkg::ST_SCAN_RD: o_cmd.scan_rd = 1'b1;
            qs_pkg::ST_SCAN_CMP: begin
                o_cmd.i_inc = i_status.i_go;
                o_cmd.j_dec = !i_status.i_go && i_status.j_go;
            end
            qs_pkg::ST_SWAP_I:  o_cmd.swap_i = 1'b1;
            qs_pkg::ST_SWAP_J:  o_cmd.swap_j = 1'b1;
            qs_pkg::ST_PUSH_L:  o_cmd.push_l = i_status.j_gt_lo;
            qs_pkg::ST_PUSH_R:  o_cmd.push_r = i_status.i_lt_hi;
            qs_pkg::ST_EM_RD:   o_cmd.emit_rd = 1'b1;
            qs_pkg::ST_EM_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.clear     = i_out_ready && i_status.emit_last;
                o_cmd.emit_next = i_out_ready && !i_status.emit_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/qs_datapath.sv */
// Datapath of the quicksort engine: element memory, range stack, partition
// indices and pivot. Depends on qs_pkg; commanded by qs_ctrl.
module qs_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qs_pkg::t_cmd                     i_cmd,
    input  logic signed [qs_pkg::ValueW-1:0] i_value,
    output qs_pkg::t_status                  o_status,
    output logic signed [qs_pkg::ValueW-1:0] o_sorted_value,
    output logic                             o_last_res,
    output logic                             o_overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] CntMax = CW'(DEPTH);
    localparam logic signed [IW-1:0] Two = IW'(2);

    logic signed [qs_pkg::ValueW-1:0] mem [DEPTH];
    logic        [2*AW-1:0]           stk [DEPTH];

    logic        [CW-1:0]             r_cnt;
    logic                             r_drop;
    logic        [CW-1:0]             r_sp;
    logic        [2*AW-1:0]           r_stk_q;
    logic        [AW-1:0]             r_lo, r_hi, r_k;
    logic signed [IW-1:0]             r_i, r_j;
    logic signed [qs_pkg::ValueW-1:0] r_pivot, r_rd_a, r_rd_b;

    logic        [AW-1:0]             stk_lo, stk_hi;
    logic signed [IW-1:0]             lo_s, hi_s;
    logic        [CW-1:0]             mid_w, cnt_m1, sp_m1;
    logic                             wr_en, rd_en_a, push_en;
    logic        [AW-1:0]             wr_addr, rd_addr_a;
    logic signed [qs_pkg::ValueW-1:0] wr_data;
    logic        [2*AW-1:0]           push_data;

    assign stk_lo = r_stk_q[2*AW-1:AW];
    assign stk_hi = r_stk_q[AW-1:0];
    assign lo_s   = $signed({2'b00, r_lo});
    assign hi_s   = $signed({2'b00, r_hi});
    assign mid_w  = CW'(r_lo) + ((CW'(r_hi) - CW'(r_lo) + CW'(1)) >> 1);
    assign cnt_m1 = r_cnt - CW'(1);
    assign sp_m1  = r_sp - CW'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_data = i_value;
        if (i_cmd.load_wr && (r_cnt < CntMax)) begin
            wr_en = 1'b1;
        end else if (i_cmd.swap_i) begin
            wr_en   = 1'b1;
            wr_addr = r_i[AW-1:0];
            wr_data = r_rd_b;
        end else if (i_cmd.swap_j) begin
            wr_en   = 1'b1;
            wr_addr = r_j[AW-1:0];
            wr_data = r_rd_a;
        end
    end

    always_comb begin
        rd_en_a   = i_cmd.pivot_rd || i_cmd.scan_rd || i_cmd.emit_rd;
        rd_addr_a = r_k;
        if (i_cmd.pivot_rd)     rd_addr_a = mid_w[AW-1:0];
        else if (i_cmd.scan_rd) rd_addr_a = r_i[AW-1:0];
    end

    always_comb begin
        push_en   = (i_cmd.push_init || i_cmd.push_l || i_cmd.push_r) && (r_sp < CntMax);
        push_data = {r_i[AW-1:0], r_hi};
        if (i_cmd.push_init)   push_data = {{AW{1'b0}}, cnt_m1[AW-1:0]};
        else if (i_cmd.push_l) push_data = {r_lo, r_j[AW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en_a) r_rd_a <= mem[rd_addr_a];
        if (i_cmd.scan_rd) r_rd_b <= mem[r_j[AW-1:0]];
        if (push_en) stk[r_sp[AW-1:0]] <= push_data;
        if (i_cmd.pop) r_stk_q <= stk[sp_m1[AW-1:0]];
        if (i_cmd.pivot_ld) r_pivot <= r_rd_a;
        if (i_cmd.range_ld) begin
            r_lo <= stk_lo;
            r_hi <= stk_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_drop <= 1'b0;
            r_sp   <= '0;
            r_k    <= '0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt  <= '0;
                r_drop <= 1'b0;
                r_k    <= '0;
            end else if (i_cmd.load_wr) begin
                if (r_cnt < CntMax) r_cnt <= r_cnt + CW'(1);
                else                r_drop <= 1'b1;
            end else if (i_cmd.emit_next) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.clear)     r_sp <= '0;
            else if (push_en)    r_sp <= r_sp + CW'(1);
            else if (i_cmd.pop)  r_sp <= sp_m1;
            if (i_cmd.range_ld) begin
                r_i <= $signed({2'b00, stk_lo});
                r_j <= $signed({2'b00, stk_hi});
            end else begin
                if (i_cmd.i_inc || i_cmd.swap_j) r_i <= r_i + IW'(1);
                if (i_cmd.j_dec || i_cmd.swap_j) r_j <= r_j - IW'(1);
            end
        end
    end

    always_comb begin
        o_status.cnt_lt2   = r_cnt < CW'(2);
        o_status.sp_zero   = r_sp == '0;
        o_status.range_ok  = stk_lo < stk_hi;
        o_status.i_go      = (r_i < hi_s) && (r_rd_a < r_pivot);
        o_status.j_go      = (r_j > lo_s) && (r_rd_b > r_pivot);
        o_status.i_le_j    = r_i <= r_j;
        o_status.swap_cont = (r_i + Two) <= r_j;
        o_status.j_gt_lo   = r_j > lo_s;
        o_status.i_lt_hi   = r_i < hi_s;
        o_status.emit_last = CW'(r_k) == cnt_m1;
    end

    assign o_sorted_value = r_rd_a;
    assign o_last_res     = o_status.emit_last;
    assign o_overflow     = r_drop;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntMax) else $error("element count beyond capacity");
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CntMax) else $error("range stack beyond capacity");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_cnt == '0) && !r_drop && (r_sp == '0))
        else $error("set state not cleared after final beat");
    a_no_drop_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_wr && (r_cnt < CntMax)) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("stored element not counted");

endmodule

/* hw/rtl/quicksort_engine.sv */
// Quicksort engine top level: joins the controller and the datapath.
// Depends on qs_pkg, qs_stream_if, qs_ctrl and qs_datapath.
//
// Use: stream signed 32-bit values on i_in, one per beat; the beat with
// last set closes the set. Input beats are taken one per cycle while the
// block is loading. Values past DEPTH are dropped and every result of that
// set carries overflow. After the closing beat the block sorts in place with
// Hoare-partition quicksort, keeping pending ranges on a stack memory, and
// takes no input until the whole set has been sent on o_out.
// Each scan step reads, then compares, as the element memory read is
// registered; a swap writes the two elements in turn, and each partitioned
// range is popped, checked, its pivot read and loaded, and its subranges pushed.
// Each result is read from the element memory, then offered on o_out; a new
// read only starts once the beat is taken.
// A stalled receiver holds the current result beat steady until taken.
// Reset empties the set, the range stack and the overflow mark; memory
// contents need no clearing.
module quicksort_engine #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    qs_stream_if.sink                i_in,
    qs_stream_if.source              o_out
);

    qs_pkg::t_cmd    cmd;
    qs_pkg::t_status status;
    qs_pkg::t_in_beat in_beat;
    logic signed [qs_pkg::ValueW-1:0] sorted_value;
    logic last_res, overflow;

    assign in_beat = i_in.data;

    qs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (in_beat.last),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    qs_datapath #(.DEPTH(DEPTH)) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (in_beat.value),
        .o_status       (status),
        .o_sorted_value (sorted_value),
        .o_last_res     (last_res),
        .o_overflow     (overflow)
    );

    assign o_out.data = '{sorted_value: sorted_value, last_res: last_res,
                          overflow: overflow};

endmodule

/* verif/qs_tb_pkg.sv */
// Testbench constants for the quicksort engine checks.
// Depends on nothing; used by tb for the engine depth and the set sizes.
package qs_tb_pkg;
    localparam int SetDepth = 64;
endpackage

/* verif/tb.sv */
// Testbench for quicksort_engine: streams sets of signed values, predicts the
// sorted output with its own Hoare-partition sort and checks every result beat.
// Depends on qs_pkg, qs_tb_pkg, qs_stream_if and quicksort_engine.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 2000000;
    localparam int SetDepth = qs_tb_pkg::SetDepth;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    qs_stream_if #(.T(qs_pkg::t_in_beat))  in_ch ();
    qs_stream_if #(.T(qs_pkg::t_out_beat)) out_ch ();

    quicksort_engine #(.DEPTH(SetDepth)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               has_exp;
        logic signed [31:0] exp_value;
    } t_row;

    logic signed [31:0] held_values[$];
    logic               held_drop;
    qs_pkg::t_out_beat  sorted_due[$];
    int                 errors;
    int                 beats_in;
    int                 beats_out;
    int                 sets_done;
    int                 cycles;
    bit                 long_hold;
    logic signed [31:0] pinned_exp[$];

    function automatic void hoare_sort(ref logic signed [31:0] a[SetDepth], input int n);
        int lo_stk[$];
        int hi_stk[$];
        int lo;
        int hi;
        int i;
        int j;
        logic signed [31:0] pivot;
        logic signed [31:0] t;
        if (n < 2) return;
        lo_stk.push_back(0);
        hi_stk.push_back(n - 1);
        while (lo_stk.size() > 0) begin
            lo = lo_stk.pop_back();
            hi = hi_stk.pop_back();
            if (lo >= hi) continue;
            i = lo;
            j = hi;
            pivot = a[lo + (hi - lo + 1) / 2];
            do begin
                while (i < hi && a[i] < pivot) i++;
                while (j > lo && a[j] > pivot) j--;
                if (i <= j) begin
                    t = a[i];
                    a[i] = a[j];
                    a[j] = t;
                    i++;
                    j--;
                end
            end while (i <= j);
            if (j > lo) begin
                lo_stk.push_back(lo);
                hi_stk.push_back(j);
            end
            if (i < hi) begin
                lo_stk.push_back(i);
                hi_stk.push_back(hi);
            end
        end
    endfunction

    function automatic void predict_sorted(logic signed [31:0] v, logic last);
        logic signed [31:0] a[SetDepth];
        qs_pkg::t_out_beat b;
        int n;
        if (held_values.size() < SetDepth) held_values.push_back(v);
        else held_drop = 1'b1;
        if (!last) return;
        n = held_values.size();
        foreach (held_values[k]) a[k] = held_values[k];
        hoare_sort(a, n);
        for (int k = 0; k < n; k++) begin
            b.sorted_value = a[k];
            b.last_res = (k == n - 1);
            b.overflow = held_drop;
            sorted_due.push_back(b);
        end
        held_values.delete();
        held_drop = 1'b0;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 7)) - 32'd3);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_beat(logic signed [31:0] v, logic last);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.data  <= '{value: v, last: last};
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_sorted(v, last);
        beats_in++;
    endtask

    task automatic send_set(int n);
        for (int k = 0; k < n; k++) send_beat(rand_value(), k == n - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sorted_due.size() > 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) stall = 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        qs_pkg::t_out_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_out++;
            if (sorted_due.size() == 0) begin
                $error("result beat with nothing expected: %0d", out_ch.data.sorted_value);
                errors++;
            end else begin
                want = sorted_due.pop_front();
                if (pinned_exp.size() > 0) begin
                    if (pinned_exp[0] !== out_ch.data.sorted_value) begin
                        $error("sorted_value: expected %0d, actual %0d",
                               pinned_exp[0], out_ch.data.sorted_value);
                        errors++;
                    end
                    void'(pinned_exp.pop_front());
                end
                if (out_ch.data.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, actual %0d",
                           want.sorted_value, out_ch.data.sorted_value);
                    errors++;
                end
                if (out_ch.data.last_res !== want.last_res) begin
                    $error("last_res: expected %0b, actual %0b",
                           want.last_res, out_ch.data.last_res);
                    errors++;
                end
                if (out_ch.data.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, out_ch.data.overflow);
                    errors++;
                end
                if (want.last_res) sets_done++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        int n;
        beats_in = 0;
        long_hold = 0;
        held_drop = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single element, extremes, duplicates and sign mix
        rows = '{
            '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff},
            '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
            '{32'sh7fff_ffff, 1'b0, 1'b0, 0},
            '{32'sh8000_0000, 1'b1, 1'b0, 0},
            '{5, 1'b0, 1'b0, 0},
            '{5, 1'b0, 1'b0, 0},
            '{5, 1'b1, 1'b0, 0},
            '{-1, 1'b0, 1'b0, 0},
            '{0, 1'b0, 1'b0, 0},
            '{1, 1'b0, 1'b0, 0},
            '{32'sh5555_5555, 1'b0, 1'b0, 0},
            '{32'shaaaa_aaaa, 1'b0, 1'b0, 0},
            '{-1, 1'b1, 1'b0, 0}
        };
        foreach (rows[r]) begin
            if (rows[r].has_exp) pinned_exp.push_back(rows[r].exp_value);
            send_beat(rows[r].value, rows[r].last);
        end
        wait_drained();

        // overflow: exactly full, then past full with the last three values dropped
        send_set(SetDepth);
        send_set(SetDepth + 3);
        wait_drained();

        // hold the receiver off while a full set goes in
        long_hold = 1'b1;
        send_set(SetDepth);
        send_set(20);
        wait_drained();

        while (beats_in < 370) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, SetDepth + 2)
                                             : $urandom_range(1, 12);
            send_set(n);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("covered %0d input beats in %0d sets, %0d result beats checked",
                 beats_in, sets_done, beats_out);
        if (errors == 0 && sorted_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/qs_pkg.sv
hw/rtl/qs_stream_if.sv
hw/rtl/qs_ctrl.sv
hw/rtl/qs_datapath.sv
hw/rtl/quicksort_engine.sv
verif/qs_tb_pkg.sv
verif/tb.sv
